// ===== hw/rtl/gregorian_date_analyzer_defines.svh =====
// Assertion macros used by the date analyser checker.
`ifndef GREGORIAN_DATE_ANALYZER_DEFINES_SVH
`define GREGORIAN_DATE_ANALYZER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and switched off during reset.
`define GDA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and switched off during reset.
`define GDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gda_pkg.sv =====
// Types, constants and calendar tables for the Gregorian date analyser.
`timescale 1ns / 1ps

package gda_pkg;

  // Field widths of the date and result items.
  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned DoyW   = 9;
  localparam int unsigned WdayW  = 3;
  localparam int unsigned MaskW  = 7;

  // Weekend mask after reset: Friday and Saturday.
  localparam logic [MaskW-1:0] WeekendMaskReset = 7'd96;

  // Division by 100 as a multiplication by a scaled reciprocal.
  localparam int unsigned RecipShift = 19;
  localparam int unsigned Recip100   = 5243;
  localparam int unsigned RecipW     = 13;
  localparam int unsigned QuotW      = 8;
  localparam int unsigned Century    = 100;
  localparam int unsigned YearOffset = 400;
  localparam int unsigned CenturyOffset = YearOffset / Century;

  // Weekday codes used by the classification.
  localparam logic [WdayW-1:0] Saturday = 3'd6;

  // Year lengths.
  localparam logic [DoyW-1:0] CommonYearLen = 9'd365;
  localparam logic [DoyW-1:0] LeapYearLen   = 9'd366;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } gda_date_t;

  typedef struct packed {
    logic [WdayW-1:0] weekday;
    logic             leap_year;
    logic [DoyW-1:0]  day_of_year;
    logic             end_of_week;
    logic             weekend_day;
    logic             business_day;
    logic [WdayW-1:0] days_to_week_end;
    logic [DayW-1:0]  days_to_month_end;
    logic [DoyW-1:0]  days_to_year_end;
    logic             date_invalid;
  } gda_result_t;

  // Length of a month; months outside 1 to 12 have no days at all.
  function automatic logic [DayW-1:0] month_len_f(input logic [MonthW-1:0] month,
                                                  input logic leap);
    logic [DayW-1:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days of a common year before the first of the month.
  function automatic logic [DoyW-1:0] days_before_f(input logic [MonthW-1:0] month);
    logic [DoyW-1:0] days;
    case (month)
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

  // Month term of the congruence, (31 * m) / 12 with m counted from March.
  function automatic logic [DayW-1:0] month_term_f(input logic [MonthW-1:0] month);
    logic [DayW-1:0] term;
    case (month)
      4'd1:    term = 5'd28;
      4'd2:    term = 5'd31;
      4'd3:    term = 5'd2;
      4'd4:    term = 5'd5;
      4'd5:    term = 5'd7;
      4'd6:    term = 5'd10;
      4'd7:    term = 5'd12;
      4'd8:    term = 5'd15;
      4'd9:    term = 5'd18;
      4'd10:   term = 5'd20;
      4'd11:   term = 5'd23;
      4'd12:   term = 5'd25;
      default: term = 5'd0;
    endcase
    return term;
  endfunction

  // Remainder by seven: octal digits are summed, since eight is one modulo seven.
  function automatic logic [WdayW-1:0] mod7_f(input logic [14:0] v);
    logic [5:0] digit_sum;
    logic [3:0] fold;
    digit_sum = '0;
    for (int i = 0; i < 5; i++) begin
      digit_sum = digit_sum + 6'(v[3*i +: 3]);
    end
    fold = {1'b0, digit_sum[5:3]} + {1'b0, digit_sum[2:0]};
    if (fold >= 4'd7) begin
      fold = fold - 4'd7;
    end
    return fold[2:0];
  endfunction

endpackage

// ===== hw/rtl/gda_channels.sv =====
// Valid/ready channel interfaces for date and result items.
`timescale 1ns / 1ps

interface gda_date_if;
  logic                valid;
  logic                ready;
  gda_pkg::gda_date_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gda_result_if;
  logic                 valid;
  logic                 ready;
  gda_pkg::gda_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/gregorian_date_analyzer.sv =====
// Top level of the Gregorian date analyser: a four-stage pipeline.
//
//   Channel     Direction  Contents
//   date_i      in         year, month, day
//   result_o    out        weekday, flags, day of year, days remaining
//   cfg_we_i    in         weekend mask write enable with cfg_wdata_i
//
// One item enters per cycle while no stall holds the input; it passes
// through the stages in order: reciprocal multiply, calendar checks,
// weekday sum and day of year, then the modulo-seven reduction into the output.
// Reset clears the valid bits and loads the weekend mask with Friday and Saturday.
// A stalled output holds the result register and each full stage with no empty stage after it; others still move.
`timescale 1ns / 1ps

module gregorian_date_analyzer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  gda_date_if.sink                         date_i,
  gda_result_if.source                     result_o,
  input  logic                             cfg_we_i,
  input  logic [gda_pkg::MaskW-1:0]        cfg_wdata_i
);

  localparam int unsigned ProdW = gda_pkg::YearW + gda_pkg::RecipW;
  localparam int unsigned YW    = gda_pkg::YearW + 1;

  // Weekend mask register.
  logic [gda_pkg::MaskW-1:0] mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= gda_pkg::WeekendMaskReset;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i;
    end
  end

  // Stage advance: a stage moves on when it is empty or the next one moves.
  logic res_v_q, s1_v_q, s2_v_q, s3_v_q;
  logic adv_out, adv3, adv2, adv1;

  assign adv_out = !res_v_q || result_o.ready;
  assign adv3    = !s3_v_q || adv_out;
  assign adv2    = !s2_v_q || adv3;
  assign adv1    = !s1_v_q || adv2;
  assign date_i.ready = adv1;

  // Stage one: year divided by 100 through the reciprocal.
  logic [ProdW-1:0]              prod;
  logic [gda_pkg::QuotW-1:0]     s1_q100_q;
  logic [gda_pkg::YearW-1:0]     s1_year_q;
  logic [gda_pkg::MonthW-1:0]    s1_month_q;
  logic [gda_pkg::DayW-1:0]      s1_day_q;

  assign prod = ProdW'(date_i.data.year) * ProdW'(gda_pkg::Recip100);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv1) begin
      s1_v_q <= date_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && date_i.valid) begin
      s1_q100_q  <= prod[gda_pkg::RecipShift +: gda_pkg::QuotW];
      s1_year_q  <= date_i.data.year;
      s1_month_q <= date_i.data.month;
      s1_day_q   <= date_i.data.day;
    end
  end

  // Stage two: leap year, shifted year and century count, month length.
  logic [gda_pkg::YearW-1:0]  hundreds;
  logic [gda_pkg::YearW-1:0]  rem_full;
  logic                       rem_zero;
  logic                       early;
  logic                       leap;
  logic [gda_pkg::QuotW-1:0]  cent;
  logic [YW-1:0]              shift_year;
  logic [gda_pkg::DayW-1:0]   mlen;

  assign hundreds   = gda_pkg::YearW'(s1_q100_q) * gda_pkg::YearW'(gda_pkg::Century);
  assign rem_full   = s1_year_q - hundreds;
  assign rem_zero   = (rem_full[6:0] == 7'd0);
  assign early      = (s1_month_q <= 4'd2);
  assign leap       = (rem_zero && (s1_q100_q[1:0] == 2'b00)) ||
                      (!rem_zero && (s1_year_q[1:0] == 2'b00));
  assign cent       = s1_q100_q + gda_pkg::QuotW'(gda_pkg::CenturyOffset)
                      - gda_pkg::QuotW'(early && rem_zero);
  assign shift_year = YW'(s1_year_q) + YW'(gda_pkg::YearOffset) - YW'(early);
  assign mlen       = gda_pkg::month_len_f(s1_month_q, leap);

  logic [YW-1:0]              s2_y_q;
  logic [gda_pkg::QuotW-1:0]  s2_cent_q;
  logic [gda_pkg::MonthW-1:0] s2_month_q;
  logic [gda_pkg::DayW-1:0]   s2_day_q;
  logic [gda_pkg::DayW-1:0]   s2_mlen_q;
  logic                       s2_leap_q;
  logic                       s2_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv2) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && s1_v_q) begin
      s2_y_q     <= shift_year;
      s2_cent_q  <= cent;
      s2_month_q <= s1_month_q;
      s2_day_q   <= s1_day_q;
      s2_mlen_q  <= mlen;
      s2_leap_q  <= leap;
      s2_bad_q   <= (s1_day_q == 5'd0) || (s1_day_q > mlen);
    end
  end

  // Stage three: weekday sum, day of year and days left in the month.
  logic [YW-1:0]             wd_sum;
  logic [gda_pkg::DoyW-1:0]  doy;

  assign wd_sum = YW'(s2_day_q) + s2_y_q + (s2_y_q >> 2) - YW'(s2_cent_q)
                  + YW'(s2_cent_q >> 2) + YW'(gda_pkg::month_term_f(s2_month_q));
  assign doy    = gda_pkg::days_before_f(s2_month_q) + gda_pkg::DoyW'(s2_day_q)
                  + gda_pkg::DoyW'(s2_leap_q && (s2_month_q > 4'd2));

  logic [YW-1:0]             s3_sum_q;
  logic [gda_pkg::DoyW-1:0]  s3_doy_q;
  logic [gda_pkg::DayW-1:0]  s3_mleft_q;
  logic                      s3_leap_q;
  logic                      s3_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (adv3) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3 && s2_v_q) begin
      s3_sum_q   <= wd_sum;
      s3_doy_q   <= doy;
      s3_mleft_q <= s2_mlen_q - s2_day_q + 5'd1;
      s3_leap_q  <= s2_leap_q;
      s3_bad_q   <= s2_bad_q;
    end
  end

  // Output stage: weekday, classification and the result register.
  logic [gda_pkg::WdayW-1:0] wday;
  logic                      wkend;
  logic [gda_pkg::DoyW-1:0]  ylen;
  gda_pkg::gda_result_t      res_d, res_q;

  assign wday  = gda_pkg::mod7_f(s3_sum_q);
  assign wkend = mask_q[wday];
  assign ylen  = s3_leap_q ? gda_pkg::LeapYearLen : gda_pkg::CommonYearLen;

  always_comb begin
    res_d = '0;
    if (s3_bad_q) begin
      res_d.date_invalid = 1'b1;
    end else begin
      res_d.weekday           = wday;
      res_d.leap_year         = s3_leap_q;
      res_d.day_of_year       = s3_doy_q;
      res_d.end_of_week       = (wday == gda_pkg::Saturday);
      res_d.weekend_day       = wkend;
      res_d.business_day      = !wkend;
      res_d.days_to_week_end  = gda_pkg::Saturday - wday;
      res_d.days_to_month_end = s3_mleft_q;
      res_d.days_to_year_end  = ylen - s3_doy_q + 9'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else if (adv_out) begin
      res_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && s3_v_q) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid = res_v_q;
  assign result_o.data  = res_q;

endmodule

// ===== hw/rtl/gda_checker.sv =====
// Port-level checker for the date analyser and its bind to the top level.
`timescale 1ns / 1ps
`include "gregorian_date_analyzer_defines.svh"

module gda_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  gda_pkg::gda_result_t  out_data_i
);

  logic in_acc;
  logic out_stall;
  logic good;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;
  assign good      = out_valid_i && !out_data_i.date_invalid;

  // A waiting result stays offered and unchanged.
  `GDA_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i && $stable(out_data_i), "result item changed while stalled")

  // With the output ready while an accepted item passes stages one to three, the item comes out.
  `GDA_ASSERT_NEXT(a_latency, in_acc ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i, out_valid_i, "accepted item did not reach the output")

  // An invalid date carries no other information.
  `GDA_ASSERT_IMPL(a_invalid_zero, out_valid_i && out_data_i.date_invalid, out_data_i.weekday == 3'd0 && out_data_i.day_of_year == 9'd0 && !out_data_i.business_day && out_data_i.days_to_month_end == 5'd0 && out_data_i.days_to_year_end == 9'd0, "invalid date with non-zero fields")

  // A valid date is consistently classified.
  `GDA_ASSERT_IMPL(a_classify, good, out_data_i.business_day != out_data_i.weekend_day && out_data_i.end_of_week == (out_data_i.weekday == gda_pkg::Saturday) && out_data_i.days_to_week_end == gda_pkg::Saturday - out_data_i.weekday, "inconsistent weekday classification")

endmodule

bind gregorian_date_analyzer gda_checker u_gda_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (date_i.valid),
  .in_ready_i  (date_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_data_i  (result_o.data)
);
